@@ rtl/fmt_pkg.sv @@
// shared types and constants of the filmic tone mapper
package fmt_pkg;

  // interface sample width (q1.16) and config data width
  localparam int unsigned EXT_W = 17;
  localparam int unsigned CFG_DW = 24;
  localparam int unsigned CFG_IW = 3;

  // config register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_EXPOSURE  = 3'd0,
    CFG_WHITE     = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_MULT      = 3'd3,
    CFG_DESAT     = 3'd4,
    CFG_TOE       = 3'd5
  } cfg_idx_e;

  // config reset values
  localparam logic [23:0] RST_EXPOSURE  = 24'd655360;
  localparam logic [19:0] RST_WHITE     = 20'd92800;
  localparam logic [16:0] RST_THRESHOLD = 17'd20477;
  localparam logic [23:0] RST_MULT      = 24'd204767;
  localparam logic [16:0] RST_DESAT     = 17'd32768;
  localparam logic        RST_TOE       = 1'b1;

  typedef struct packed {
    logic [23:0] expo_gain;
    logic [19:0] white_scale;
    logic [16:0] ldr_threshold;
    logic [23:0] ldr_mult;
    logic [16:0] desat_amount;
    logic        linear_toe;
  } cfg_t;

  typedef struct packed {
    logic [EXT_W-1:0] red_in;
    logic [EXT_W-1:0] green_in;
    logic [EXT_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [EXT_W-1:0] red_out;
    logic [EXT_W-1:0] green_out;
    logic [EXT_W-1:0] blue_out;
  } pix_out_t;

endpackage

@@ rtl/fmt_dly.sv @@
// stallable delay line for values that ride alongside the pipeline
module fmt_dly import fmt_pkg::*; #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  generate
    if (N == 0) begin : g_none
      assign q_o = d_i;
    end else begin : g_line
      logic [W-1:0] sr_q [N];
      // shift on every advance of the pipeline
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sr_q[0] <= d_i;
          for (int k = 1; k < N; k++) begin
            sr_q[k] <= sr_q[k-1];
          end
        end
      end
      assign q_o = sr_q[N-1];
    end
  endgenerate

endmodule

@@ rtl/fmt_div.sv @@
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module fmt_div import fmt_pkg::*; #(
  parameter int DVW = 16,
  parameter int DSW = 8,
  parameter int QW  = 8,
  parameter int TGW = 1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [DVW-1:0] a_i,
  input  logic [DSW-1:0] b_i,
  input  logic [TGW-1:0] tag_i,
  output logic [QW-1:0]  q_o,
  output logic [TGW-1:0] tag_o
);

  localparam int HW  = DVW - QW;
  localparam int CMW = (HW > DSW) ? HW : DSW;

  logic [DSW-1:0] rem_q [QW+1];
  logic [DSW-1:0] dvs_q [QW+1];
  logic [QW-1:0]  alo_q [QW+1];
  logic [QW-1:0]  quo_q [QW+1];
  logic           ovf_q [QW+1];
  logic [TGW-1:0] tag_q [QW+1];

  logic [HW-1:0] a_hi;
  logic          ovf;

  // entry: quotient would not fit when the upper dividend part reaches the divisor
  assign a_hi = a_i[DVW-1:QW];
  assign ovf  = CMW'(a_hi) >= CMW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DSW'(a_hi);
      dvs_q[0] <= b_i;
      alo_q[0] <= a_i[QW-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= ovf;
      tag_q[0] <= tag_i;
    end
  end

  // one trial subtraction per stage
  generate
    for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [DSW:0] trial;
      logic [DSW:0] diff;
      logic         ge;
      assign trial = {rem_q[k-1], alo_q[k-1][QW-k]};
      assign diff  = trial - {1'b0, dvs_q[k-1]};
      assign ge    = trial >= {1'b0, dvs_q[k-1]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
          dvs_q[k] <= dvs_q[k-1];
          alo_q[k] <= alo_q[k-1];
          quo_q[k] <= (quo_q[k-1] << 1) | QW'(ge);
          ovf_q[k] <= ovf_q[k-1];
          tag_q[k] <= tag_q[k-1];
        end
      end
    end
  endgenerate

  assign q_o   = ovf_q[QW] ? '1 : quo_q[QW];
  assign tag_o = tag_q[QW];

endmodule

@@ rtl/fmt_luma.sv @@
// two-stage weighted sum of three channels with the bt.2020 luma weights
module fmt_luma import fmt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int IW = 17,
  parameter int OW = 18
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [IW-1:0] x_i [3],
  output logic [OW-1:0] y_o
);

  localparam int F = FRAC_BITS;
  localparam logic [F-1:0] WGT [3] = '{
    F'(((64'd2627 << F) + 64'd5000) / 64'd10000),
    F'(((64'd678 << F) + 64'd500) / 64'd1000),
    F'(((64'd593 << F) + 64'd5000) / 64'd10000)
  };

  logic [F+IW-1:0] p_q [3];
  logic [F+IW+1:0] sm;
  logic [OW-1:0]   y_q;

  // weight products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        p_q[k] <= WGT[k] * x_i[k];
      end
    end
  end

  // sum and drop the fraction
  assign sm = (F+IW+2)'(p_q[0]) + (F+IW+2)'(p_q[1]) + (F+IW+2)'(p_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= OW'(sm >> F);
    end
  end

  assign y_o = y_q;

endmodule

@@ rtl/fmt_lane.sv @@
// one channel of the filmic curve with white gain, clamp and linear toe
module fmt_lane import fmt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0,
  localparam int DN  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS,
  localparam int CW  = 17 + UP - DN,
  localparam int MW  = 24 + UP - DN,
  localparam int VW  = CW + MW - FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  cfg_t          cfg_i,
  input  logic [CW-1:0] c_i,
  output logic [VW-1:0] v_o
);

  localparam int F   = FRAC_BITS;
  localparam int EW  = 24 + UP - DN;
  localparam int WSW = 20 + UP - DN;
  localparam int HW  = 17 + UP - DN;
  localparam int XW  = CW + EW - F;
  localparam int NW  = 2 * XW + 2 - F;

  localparam logic [63:0] ONE   = 64'd1 << F;
  localparam logic [63:0] C015  = ((64'd15 << F) + 64'd50) / 64'd100;
  localparam logic [63:0] C005  = ((64'd5 << F) + 64'd50) / 64'd100;
  localparam logic [63:0] C0004 = ((64'd4 << F) + 64'd500) / 64'd1000;
  localparam logic [63:0] C050  = ((64'd1 << F) + 64'd1) / 64'd2;
  localparam logic [63:0] C006  = ((64'd6 << F) + 64'd50) / 64'd100;
  localparam logic [63:0] COFS  = ((64'd1 << F) + 64'd7) / 64'd15;

  logic [EW-1:0]  e_int;
  logic [MW-1:0]  mult_int;
  logic [WSW-1:0] ws_int;
  logic [HW-1:0]  thr_int;

  assign e_int    = EW'((64'(cfg_i.expo_gain) << UP) >> DN);
  assign mult_int = MW'((64'(cfg_i.ldr_mult) << UP) >> DN);
  assign ws_int   = WSW'((64'(cfg_i.white_scale) << UP) >> DN);
  assign thr_int  = HW'((64'(cfg_i.ldr_threshold) << UP) >> DN);

  // exposure and toe products
  logic [CW+EW-1:0] xp;
  logic [CW+MW-1:0] tvp;
  logic [XW-1:0]    x1_q;
  logic [VW-1:0]    tv1_q;

  assign xp  = c_i * e_int;
  assign tvp = c_i * mult_int;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= xp[CW+EW-1:F];
      tv1_q <= tvp[CW+MW-1:F];
    end
  end

  // quadratic term coefficient
  logic [F+XW-1:0] tp;
  logic [XW-1:0]   t2_q;
  logic [XW-1:0]   x2_q;
  logic [VW-1:0]   tv2_q;

  assign tp = F'(C015) * x1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q  <= tp[F+XW-1:F];
      x2_q  <= x1_q;
      tv2_q <= tv1_q;
    end
  end

  // numerator and denominator of the rational curve
  logic [XW:0]   na;
  logic [XW:0]   da;
  logic [2*XW:0] nm;
  logic [2*XW:0] dm;
  logic [NW-1:0] num_q;
  logic [NW-1:0] den_q;
  logic [VW-1:0] tv3_q;

  assign na = {1'b0, t2_q} + (XW+1)'(C005);
  assign da = {1'b0, t2_q} + (XW+1)'(C050);
  assign nm = x2_q * na;
  assign dm = x2_q * da;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= NW'(nm[2*XW:F]) + NW'(C0004);
      den_q <= NW'(dm[2*XW:F]) + NW'(C006);
      tv3_q <= tv2_q;
    end
  end

  // curve ratio, below one since the numerator stays under the denominator
  logic [F-1:0]  ratio;
  logic [VW-1:0] tv4;

  fmt_div #(
    .DVW(NW + F),
    .DSW(NW),
    .QW (F),
    .TGW(VW)
  ) u_div (
    .clk_i(clk_i),
    .en_i (en_i),
    .a_i  ({num_q, {F{1'b0}}}),
    .b_i  (den_q),
    .tag_i(tv3_q),
    .q_o  (ratio),
    .tag_o(tv4)
  );

  // offset, white gain, clamp and toe select
  logic [F+WSW-1:0] wp;
  logic [WSW-1:0]   vc;
  logic [F:0]       vcl;
  logic [VW-1:0]    v_q;

  assign wp  = (ratio - F'(COFS)) * ws_int;
  assign vc  = wp[F+WSW-1:F];
  assign vcl = (ratio > F'(COFS)) ? ((vc > WSW'(ONE)) ? (F+1)'(ONE) : (F+1)'(vc)) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cfg_i.linear_toe && (vcl < thr_int)) begin
        v_q <= tv4;
      end else begin
        v_q <= VW'(vcl);
      end
    end
  end

  assign v_o = v_q;

endmodule

@@ rtl/fmt_mix.sv @@
// merge of the lanes: tone luma, mask, desaturation blend, luma ratio and output clamp
module fmt_mix import fmt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0,
  localparam int DN  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS,
  localparam int CW  = 17 + UP - DN,
  localparam int LW  = CW + 1,
  localparam int VW  = CW + 24 + UP - DN - FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  cfg_t           cfg_i,
  input  logic [VW-1:0]  v_i [3],
  input  logic [CW-1:0]  c_i [3],
  input  logic [LW-1:0]  l_i,
  input  logic [LW-1:0]  q_i,
  input  logic           mz_i,
  output logic [FRAC_BITS:0] o_o [3]
);

  localparam int F   = FRAC_BITS;
  localparam int HW  = 17 + UP - DN;
  localparam int TW  = VW + 2;
  localparam int SQW = 2 * F + 2;
  localparam int PW  = LW + SQW;
  localparam int TGW = 3 * LW + 1;

  localparam logic [63:0] ONE = 64'd1 << F;
  localparam logic [63:0] LIM = ((ONE + 64'd1) << F) - 64'd1;

  // desaturation weight, saturated to one
  logic [HW-1:0] d_int;
  logic [F:0]    dsat;
  logic [F:0]    omd;

  assign d_int = HW'((64'(cfg_i.desat_amount) << UP) >> DN);
  assign dsat  = (d_int > HW'(ONE)) ? (F+1)'(ONE) : (F+1)'(d_int);
  assign omd   = (F+1)'(ONE) - dsat;

  // tone-mapped luma of the curved channels
  logic [TW-1:0] t_lu;

  fmt_luma #(
    .FRAC_BITS(F),
    .IW       (VW),
    .OW       (TW)
  ) u_tluma (
    .clk_i(clk_i),
    .en_i (en_i),
    .x_i  (v_i),
    .y_o  (t_lu)
  );

  // mask from source luma and the toe threshold ratio
  logic [LW-1:0]     ldiff;
  logic [F:0]        mask;
  logic [LW+F:0]     ld;
  logic [CW+F:0]     cd [3];
  logic [F:0]        m1_q;
  logic [LW+F:0]     ld_q;
  logic [CW+F:0]     cd_q [3];
  logic [CW-1:0]     c1_q [3];
  logic [LW-1:0]     l1_q;

  assign ldiff = l_i - q_i;
  assign mask  = (!mz_i && (l_i > q_i)) ?
                 ((ldiff > LW'(ONE)) ? (F+1)'(ONE) : (F+1)'(ldiff)) : '0;
  assign ld    = l_i * dsat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cd[k] = c_i[k] * omd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= mask;
      ld_q <= ld;
      cd_q <= cd;
      c1_q <= c_i;
      l1_q <= l_i;
    end
  end

  // desaturated mix per channel
  logic [LW-1:0] as_q [3];
  logic [F:0]    m2_q;
  logic [CW-1:0] c2_q [3];
  logic [LW-1:0] l2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        as_q[k] <= LW'(((LW+F+2)'(ld_q) + (LW+F+2)'(cd_q[k])) >> F);
      end
      m2_q <= m1_q;
      c2_q <= c1_q;
      l2_q <= l1_q;
    end
  end

  // blend products toward the mix by the mask
  logic [F:0]     omm;
  logic [CW+F:0]  b1_q [3];
  logic [LW+F:0]  b2_q [3];
  logic [TW-1:0]  t3_q;
  logic [LW-1:0]  l3_q;

  assign omm = (F+1)'(ONE) - m2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        b1_q[k] <= c2_q[k] * omm;
        b2_q[k] <= as_q[k] * m2_q;
      end
      t3_q <= t_lu;
      l3_q <= l2_q;
    end
  end

  // blended channels
  logic [LW-1:0] bl_q [3];
  logic [TW-1:0] t4_q;
  logic [LW-1:0] l4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        bl_q[k] <= LW'(((LW+F+2)'(b1_q[k]) + (LW+F+2)'(b2_q[k])) >> F);
      end
      t4_q <= t3_q;
      l4_q <= l3_q;
    end
  end

  // luma ratio, saturating well above the output limit
  logic [SQW-1:0] s;
  logic [TGW-1:0] tg;

  fmt_div #(
    .DVW(TW + F),
    .DSW(LW),
    .QW (SQW),
    .TGW(TGW)
  ) u_div (
    .clk_i(clk_i),
    .en_i (en_i),
    .a_i  ({t4_q, {F{1'b0}}}),
    .b_i  (l4_q),
    .tag_i({l4_q == '0, bl_q[2], bl_q[1], bl_q[0]}),
    .q_o  (s),
    .tag_o(tg)
  );

  // scale the blended channels, zero source luma gives zero
  logic [PW-1:0] p_q [3];
  logic [F:0]    o_q [3];

  generate
    for (genvar k = 0; k < 3; k++) begin : g_out
      logic [PW-1:0] pr;
      assign pr = tg[k*LW +: LW] * s;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p_q[k] <= tg[3*LW] ? '0 : pr;
        end
      end
      // clamp to one
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          o_q[k] <= (p_q[k] > PW'(LIM)) ? (F+1)'(ONE) : (F+1)'(p_q[k] >> F);
        end
      end
      assign o_o[k] = o_q[k];
    end
  endgenerate

endmodule

@@ rtl/filmic_tonemap_luma_desat.sv @@
// top level of the filmic tone mapper with luma-guided desaturation
//
// Usage: one linear rgb pixel enters on the in channel (valid/ready) and one
// tone-mapped pixel leaves on the out channel (valid/ready), in order.
// The pipeline is 3*FRAC_BITS+14 stages deep and takes one pixel per clock
// while the receiver does not stall. Most of the depth lies in the dividers:
// the curve ratio in each channel lane (FRAC_BITS+1 stages) and the
// tone-to-source luma ratio in the merge (2*FRAC_BITS+3 stages), each
// resolving one quotient bit per stage after an entry register.
// The three color channels run in parallel lanes; the merge forms the tone
// luma, the saturation mask and the final blend.
// Reset clears all pipeline valid flags and loads the default configuration.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while the pipeline holds no pixel, the block does not
// enforce this. When the receiver stalls, the whole pipeline freezes and
// in_ready_o drops until the waiting output pixel is taken.
module filmic_tonemap_luma_desat import fmt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pix_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pix_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int F   = FRAC_BITS;
  localparam int UP  = (F >= 16) ? F - 16 : 0;
  localparam int DN  = (F >= 16) ? 0 : 16 - F;
  localparam int CW  = 17 + UP - DN;
  localparam int HW  = 17 + UP - DN;
  localparam int MW  = 24 + UP - DN;
  localparam int LW  = CW + 1;
  localparam int VW  = CW + MW - F;
  localparam int DL  = F + 5;
  localparam int DT  = 3 * F + 14;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expo_gain     <= RST_EXPOSURE;
      cfg_q.white_scale   <= RST_WHITE;
      cfg_q.ldr_threshold <= RST_THRESHOLD;
      cfg_q.ldr_mult      <= RST_MULT;
      cfg_q.desat_amount  <= RST_DESAT;
      cfg_q.linear_toe    <= RST_TOE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_EXPOSURE:  cfg_q.expo_gain     <= cfg_data_i[23:0];
        CFG_WHITE:     cfg_q.white_scale   <= cfg_data_i[19:0];
        CFG_THRESHOLD: cfg_q.ldr_threshold <= cfg_data_i[16:0];
        CFG_MULT:      cfg_q.ldr_mult      <= cfg_data_i[23:0];
        CFG_DESAT:     cfg_q.desat_amount  <= cfg_data_i[16:0];
        CFG_TOE:       cfg_q.linear_toe    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // pipeline advance and valid flags
  logic        en;
  logic [DT:1] vld_q;

  assign en          = !vld_q[DT] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[DT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DT-1:1], in_valid_i};
    end
  end

  // input samples in internal fixed point
  logic [CW-1:0] c_int [3];

  assign c_int[0] = CW'((64'(in_data_i.red_in) << UP) >> DN);
  assign c_int[1] = CW'((64'(in_data_i.green_in) << UP) >> DN);
  assign c_int[2] = CW'((64'(in_data_i.blue_in) << UP) >> DN);

  // source luma
  logic [LW-1:0] l_src;

  fmt_luma #(
    .FRAC_BITS(F),
    .IW       (CW),
    .OW       (LW)
  ) u_sluma (
    .clk_i(clk_i),
    .en_i (en),
    .x_i  (c_int),
    .y_o  (l_src)
  );

  // toe threshold over toe gain, zero gain flagged alongside
  logic [HW-1:0] thr_int;
  logic [MW-1:0] mult_int;
  logic [LW-1:0] q_div;
  logic          mz_div;

  assign thr_int  = HW'((64'(cfg_q.ldr_threshold) << UP) >> DN);
  assign mult_int = MW'((64'(cfg_q.ldr_mult) << UP) >> DN);

  fmt_div #(
    .DVW(HW + F),
    .DSW(MW),
    .QW (LW),
    .TGW(1)
  ) u_qdiv (
    .clk_i(clk_i),
    .en_i (en),
    .a_i  ({thr_int, {F{1'b0}}}),
    .b_i  (mult_int),
    .tag_i(mult_int == '0),
    .q_o  (q_div),
    .tag_o(mz_div)
  );

  // channel lanes
  logic [VW-1:0] v_lane [3];

  generate
    for (genvar k = 0; k < 3; k++) begin : g_lane
      fmt_lane #(
        .FRAC_BITS(F)
      ) u_lane (
        .clk_i(clk_i),
        .en_i (en),
        .cfg_i(cfg_q),
        .c_i  (c_int[k]),
        .v_o  (v_lane[k])
      );
    end
  endgenerate

  // align source values with the lane outputs
  logic [3*CW-1:0] c_dl;
  logic [LW-1:0]   l_dl;
  logic [LW:0]     q_dl;
  logic [CW-1:0]   c_mix [3];

  fmt_dly #(.W(3 * CW), .N(DL)) u_cdly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({c_int[2], c_int[1], c_int[0]}),
    .q_o  (c_dl)
  );

  fmt_dly #(.W(LW), .N(DL - 2)) u_ldly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (l_src),
    .q_o  (l_dl)
  );

  fmt_dly #(.W(LW + 1), .N(DL - LW - 1)) u_qdly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({mz_div, q_div}),
    .q_o  (q_dl)
  );

  assign c_mix[0] = c_dl[CW-1:0];
  assign c_mix[1] = c_dl[2*CW-1:CW];
  assign c_mix[2] = c_dl[3*CW-1:2*CW];

  // merge stage
  logic [F:0] o_mix [3];

  fmt_mix #(
    .FRAC_BITS(F)
  ) u_mix (
    .clk_i(clk_i),
    .en_i (en),
    .cfg_i(cfg_q),
    .v_i  (v_lane),
    .c_i  (c_mix),
    .l_i  (l_dl),
    .q_i  (q_dl[LW-1:0]),
    .mz_i (q_dl[LW]),
    .o_o  (o_mix)
  );

  // back to 16 fraction bits
  assign out_data_o.red_out   = EXT_W'((64'(o_mix[0]) << DN) >> UP);
  assign out_data_o.green_out = EXT_W'((64'(o_mix[1]) << DN) >> UP);
  assign out_data_o.blue_out  = EXT_W'((64'(o_mix[2]) << DN) >> UP);

endmodule

@@ rtl/fmt_chk.sv @@
// port-level checker of the tone mapper and its bind to the top level
module fmt_chk import fmt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pix_out_t out_data_o
);

  // a waiting output item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // a waiting output item keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output item changed while stalled");

  // input is refused only while an output item waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused without an output stall");

  // delivered channels never exceed one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.red_out <= 17'd65536 &&
                    out_data_o.green_out <= 17'd65536 &&
                    out_data_o.blue_out <= 17'd65536)
    else $error("output channel above one");

  // with no output item pending the input is always open
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with an empty output");

endmodule

bind filmic_tonemap_luma_desat fmt_chk u_chk (.*);

@@ tb/tb_top.sv @@
// testbench for the filmic tone mapper: self-checking against a fixed-point predictor
module tb_top;
  import fmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam int LATENCY = 3 * FB + 14;

  // fixed-point constants, rounded at FB fraction bits
  localparam longint unsigned K_WR = ((64'd2627 << FB) + 5000) / 10000;
  localparam longint unsigned K_WG = ((64'd678 << FB) + 500) / 1000;
  localparam longint unsigned K_WB = ((64'd593 << FB) + 5000) / 10000;
  localparam longint unsigned K_015 = ((64'd15 << FB) + 50) / 100;
  localparam longint unsigned K_005 = ((64'd5 << FB) + 50) / 100;
  localparam longint unsigned K_0004 = ((64'd4 << FB) + 500) / 1000;
  localparam longint unsigned K_050 = ((64'd1 << FB) + 1) / 2;
  localparam longint unsigned K_006 = ((64'd6 << FB) + 50) / 100;
  localparam longint unsigned K_OFS = ((64'd1 << FB) + 7) / 15;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  pix_in_t in_data_i;
  pix_out_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;

  filmic_tonemap_luma_desat dut (.*);

  // shadow copy of the configuration
  longint unsigned sh_expo, sh_white, sh_thr, sh_mult, sh_desat, sh_toe;

  pix_out_t expected_pixels[$];
  int mismatches;
  int send_idle_pct, recv_stall_pct;
  bit long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned tone_curve(longint unsigned c);
    longint unsigned x, na, da, num, den, ratio, v;
    x = (c * sh_expo) >> FB;
    na = ((K_015 * x) >> FB) + K_005;
    da = ((K_015 * x) >> FB) + K_050;
    num = ((x * na) >> FB) + K_0004;
    den = ((x * da) >> FB) + K_006;
    ratio = (num << FB) / den;
    v = 0;
    if (ratio > K_OFS) begin
      v = ((ratio - K_OFS) * sh_white) >> FB;
      if (v > ONE) v = ONE;
    end
    if (sh_toe != 0 && v < sh_thr) v = (c * sh_mult) >> FB;
    return v;
  endfunction

  function automatic longint unsigned weighted_luma(longint unsigned r, longint unsigned g,
                                                    longint unsigned b);
    return (K_WR * r + K_WG * g + K_WB * b) >> FB;
  endfunction

  function automatic logic [EXT_W-1:0] blend_scale(longint unsigned c, longint unsigned lum,
                                                   longint unsigned m, longint unsigned s);
    longint unsigned d, asat, bl, lim;
    d = (sh_desat > ONE) ? ONE : sh_desat;
    asat = (lum * d + c * (ONE - d)) >> FB;
    bl = (c * (ONE - m) + asat * m) >> FB;
    if (bl == 0 || s == 0) return '0;
    lim = ((ONE + 1) << FB) - 1;
    if (s > lim / bl) return ONE[EXT_W-1:0];
    bl = (bl * s) >> FB;
    return (bl > ONE) ? ONE[EXT_W-1:0] : bl[EXT_W-1:0];
  endfunction

  function automatic pix_out_t tonemap_pixel(pix_in_t p);
    longint unsigned r, g, b, lum, tl, m, s, q;
    pix_out_t o;
    r = p.red_in;
    g = p.green_in;
    b = p.blue_in;
    lum = weighted_luma(r, g, b);
    tl = weighted_luma(tone_curve(r), tone_curve(g), tone_curve(b));
    m = 0;
    s = 0;
    if (sh_mult != 0) begin
      q = (sh_thr << FB) / sh_mult;
      if (lum > q) m = (lum - q > ONE) ? ONE : lum - q;
    end
    if (lum != 0) s = (tl << FB) / lum;
    o.red_out = blend_scale(r, lum, m, s);
    o.green_out = blend_scale(g, lum, m, s);
    o.blue_out = blend_scale(b, lum, m, s);
    return o;
  endfunction

  // send one pixel, with random idle cycles before it; valid stays up after
  // the accept so that a following item can go out back to back
  task automatic send_pixel(pix_in_t p);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    expected_pixels.push_back(tonemap_pixel(p));
    // ready is steady between the falling and the next rising edge
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic send_rgb(int r, int g, int b);
    pix_in_t p;
    p.red_in = r[EXT_W-1:0];
    p.green_in = g[EXT_W-1:0];
    p.blue_in = b[EXT_W-1:0];
    send_pixel(p);
  endtask

  function automatic int rand_chan();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 0;
    if (k == 1) return 65536;
    if (k < 5) return $urandom_range(4096);
    return $urandom_range(65536);
  endfunction

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, longint unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DW-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_EXPOSURE:  sh_expo = val & 64'hFFFFFF;
      CFG_WHITE:     sh_white = val & 64'hFFFFF;
      CFG_THRESHOLD: sh_thr = val & 64'h1FFFF;
      CFG_MULT:      sh_mult = val & 64'hFFFFFF;
      CFG_DESAT:     sh_desat = val & 64'h1FFFF;
      default:       sh_toe = val & 64'h1;
    endcase
  endtask

  task automatic write_all(longint unsigned e, longint unsigned w, longint unsigned t,
                           longint unsigned m, longint unsigned d, longint unsigned toe);
    drain_pipe();
    write_reg(CFG_EXPOSURE, e);
    write_reg(CFG_WHITE, w);
    write_reg(CFG_THRESHOLD, t);
    write_reg(CFG_MULT, m);
    write_reg(CFG_DESAT, d);
    write_reg(CFG_TOE, toe);
    cfg_we_i <= 1'b0;
  endtask

  // field extremes, zero luma, inputs at one
  task automatic test_directed();
    send_rgb(0, 0, 0);
    send_rgb(65536, 65536, 65536);
    send_rgb(131071, 131071, 131071);
    send_rgb(65536, 0, 0);
    send_rgb(0, 65536, 0);
    send_rgb(0, 0, 65536);
    send_rgb(1, 1, 1);
    send_rgb(1, 0, 0);
    send_rgb(32768, 16384, 8192);
    send_rgb(100, 65536, 3);
    send_rgb(43690, 87381, 21845);
    send_rgb(20000, 20000, 20000);
  endtask

  // random pixels under the given sender idle and receiver stall mix
  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      if ($urandom_range(19) == 0) begin
        pix_in_t p;
        p = pix_in_t'({$urandom, $urandom});
        send_pixel(p);
      end else begin
        send_rgb(rand_chan(), rand_chan(), rand_chan());
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off long while the sender keeps going
  task automatic test_backpressure();
    long_hold = 1'b1;
    test_random(120, 0, 0);
    long_hold = 1'b0;
  endtask

  // configuration sweep: extremes, zero toe gain, desat above one
  task automatic test_configs();
    write_all(0, 0, 0, 0, 0, 0);
    test_directed();
    write_all(24'hFFFFFF, 20'hFFFFF, 65536, 24'hFFFFFF, 65536, 1);
    test_directed();
    write_all(655360, 92800, 20477, 0, 131071, 1);
    test_random(80, 0, 0);
    write_all(24'hFFFFFF, 20'hFFFFF, 131071, 24'hFFFFFF, 131071, 0);
    test_random(60, 0, 0);
    write_all(65536, 65536, 1, 1, 1, 1);
    test_random(60, 0, 0);
    write_all($urandom_range(24'hFFFFFF), $urandom_range(20'hFFFFF),
              $urandom_range(65536), $urandom_range(24'hFFFFFF), $urandom_range(65536), 1);
    test_random(80, 0, 0);
    write_all(655360, 92800, 20477, 204767, 32768, 1);
  endtask

  // receiver: random stalls plus one long hold
  initial begin
    int hold_cycles;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 300) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        long_hold = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  initial begin
    pix_out_t exp_pix;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel %h", out_data_o);
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (exp_pix !== out_data_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       exp_pix.red_out, exp_pix.green_out, exp_pix.blue_out,
                       out_data_o.red_out, out_data_o.green_out, out_data_o.blue_out);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("FAIL filmic_tonemap_luma_desat");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold = 1'b0;
    sh_expo = 655360;
    sh_white = 92800;
    sh_thr = 20477;
    sh_mult = 204767;
    sh_desat = 32768;
    sh_toe = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_configs();
    test_random(100, 0, 0);
    test_random(250, 83, 0);
    test_random(250, 0, 83);
    test_random(250, 23, 23);
    test_backpressure();
    drain_pipe();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS filmic_tonemap_luma_desat");
    end else begin
      $display("FAIL filmic_tonemap_luma_desat");
    end
    $finish;
  end
endmodule

@@ filmic_tonemap_luma_desat.f @@
rtl/fmt_pkg.sv
rtl/fmt_dly.sv
rtl/fmt_div.sv
rtl/fmt_luma.sv
rtl/fmt_lane.sv
rtl/fmt_mix.sv
rtl/filmic_tonemap_luma_desat.sv
rtl/fmt_chk.sv
tb/tb_top.sv
